[rtl/core/ffra_pkg.sv]
// Shared types and constants for the first-fit range allocator.
package ffra_pkg;

  localparam int unsigned DEFAULT_MAX_ENTRIES = 64;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } ffra_cmd_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_ZERO     = 3'd1,
    STAT_NOSPACE  = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_MISMATCH = 3'd4,
    STAT_NOTFOUND = 3'd5
  } ffra_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_PLACE,
    S_SHIFT_UP,
    S_INSERT,
    S_SCAN_F,
    S_SHIFT_DN,
    S_REMOVE
  } ffra_state_e;

  typedef struct packed {
    ffra_cmd_e   command;
    logic [31:0] request_size;
    logic [31:0] free_offset;
  } ffra_req_t;

  typedef struct packed {
    ffra_status_e status;
    logic [31:0]  range_offset;
    logic [31:0]  range_size;
  } ffra_rsp_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] length;
  } ffra_entry_t;

  // Update request from the sequencer to the free-byte counter.
  typedef struct packed {
    logic        take;
    logic        give;
    logic [31:0] amount;
  } ffra_cnt_op_t;

endpackage

[rtl/core/ffra_free_count.sv]
// Region size register and saturating free-byte counter.
module ffra_free_count (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_wdata_i,
  input  ffra_pkg::ffra_cnt_op_t op_i,
  output logic [31:0]           free_bytes_o,
  output logic [31:0]           region_size_o
);
  import ffra_pkg::*;

  logic [31:0] region_q, region_d;
  logic [31:0] free_q, free_d;
  logic [31:0] used;
  logic [32:0] sum;

  always_comb begin
    region_d = region_q;
    free_d   = free_q;
    used     = (free_q > region_q) ? 32'd0 : (region_q - free_q);
    sum      = {1'b0, free_q} + {1'b0, op_i.amount};
    if (cfg_we_i) begin
      // The bytes in use carry over to the new region size.
      region_d = cfg_wdata_i;
      free_d   = (cfg_wdata_i >= used) ? (cfg_wdata_i - used) : 32'd0;
    end else if (op_i.take) begin
      free_d = (free_q >= op_i.amount) ? (free_q - op_i.amount) : 32'd0;
    end else if (op_i.give) begin
      free_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= '0;
      free_q   <= '0;
    end else begin
      region_q <= region_d;
      free_q   <= free_d;
    end
  end

  assign free_bytes_o  = free_q;
  assign region_size_o = region_q;

endmodule

[rtl/core/first_fit_range_allocator.sv]
// First-fit range allocator: sorted range table in memory and its sequencer.
//
//   Port group    Dir  Handshake              Content
//   start/req_i   in   start & !busy          command, request_size, free_offset
//   rsp_o         out  rsp_valid_o, 1 cycle   status, range_offset, range_size
//   cfg_*         in   cfg_we_i               region_size
//
// The table has one read and one write port, so a scan or a shift moves one entry a cycle.
// An allocate scans for the first gap between entries that fits (with no gaps, only the
// last entry), shifts the entries above that place one slot up and inserts the range, or
// reports no space. A free scans for its offset, shifts the entries above it one slot down
// and removes it, or reports not found. A rejected item is answered without raising busy;
// any other result shows in the cycle in which busy falls. Reset empties the table and
// clears the region size; the receiver cannot stall the result.
module first_fit_range_allocator #(
  parameter int unsigned MAX_ENTRIES = ffra_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ffra_pkg::ffra_req_t req_i,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic               rsp_valid_o,
  output ffra_pkg::ffra_rsp_t rsp_o
);
  import ffra_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  ffra_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          gaps_q, gaps_d;
  logic [31:0]   size_q, size_d;
  logic [31:0]   off_q, off_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] pos_q, pos_d;
  logic          first_q, first_d;
  logic [32:0]   prev_end_q, prev_end_d;
  logic [31:0]   new_off_q, new_off_d;
  logic [31:0]   len_q, len_d;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  ffra_rsp_t     rsp_q, rsp_d;
  logic          rsp_valid_q, rsp_valid_d;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  ffra_entry_t   wr_data;
  ffra_entry_t   rd_data_q;
  ffra_entry_t   mem [MAX_ENTRIES];

  ffra_cnt_op_t  cnt_op;
  logic [31:0]   free_bytes;
  logic [31:0]   region_size;

  logic [32:0]   end_k;
  logic          fit;
  logic          place_over;
  logic          rd_last;
  logic [CW-1:0] ptr_dec;

  ffra_free_count u_free_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (cnt_op),
    .free_bytes_o  (free_bytes),
    .region_size_o (region_size)
  );

  // Range table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign end_k      = {1'b0, rd_data_q.offset} + {1'b0, rd_data_q.length};
  assign fit        = !first_q &&
                      ({2'b0, rd_data_q.offset} >= ({1'b0, prev_end_q} + {2'b0, size_q}));
  assign place_over = ({1'b0, prev_end_q} + {2'b0, size_q}) > {2'b0, region_size};
  assign rd_last    = (CW'(rd_idx_q) == (cnt_q - CW'(1)));
  assign ptr_dec    = ptr_q - CW'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    gaps_d      = gaps_q;
    size_d      = size_q;
    off_d       = off_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    first_d     = first_q;
    prev_end_d  = prev_end_q;
    new_off_d   = new_off_q;
    len_d       = len_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = ptr_q[IW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = rd_data_q;
    cnt_op      = '{take: 1'b0, give: 1'b0, amount: size_q};

    case (state_q)
      S_IDLE: begin
        if (start) begin
          size_d = req_i.request_size;
          off_d  = req_i.free_offset;
          if (req_i.command == CMD_FREE) begin
            if (cnt_q == '0) begin
              rsp_d       = '{status: STAT_NOTFOUND, range_offset: req_i.free_offset,
                              range_size: 32'd0};
              rsp_valid_d = 1'b1;
            end else begin
              ptr_d   = '0;
              state_d = S_SCAN_F;
            end
          end else if (req_i.request_size == 32'd0) begin
            rsp_d       = '{status: STAT_ZERO, range_offset: 32'd0, range_size: 32'd0};
            rsp_valid_d = 1'b1;
          end else if (cnt_q == CW'(MAX_ENTRIES)) begin
            rsp_d       = '{status: STAT_FULL, range_offset: 32'd0, range_size: 32'd0};
            rsp_valid_d = 1'b1;
          end else if (gaps_q && (free_bytes <= req_i.request_size)) begin
            rsp_d       = '{status: STAT_NOSPACE, range_offset: 32'd0, range_size: 32'd0};
            rsp_valid_d = 1'b1;
          end else if (cnt_q == '0) begin
            prev_end_d = '0;
            state_d    = S_PLACE;
          end else begin
            // Without gaps only the last entry matters for end placement.
            first_d = 1'b1;
            ptr_d   = gaps_q ? '0 : (cnt_q - CW'(1));
            state_d = S_SCAN_A;
          end
        end
      end

      S_SCAN_A: begin
        if (rd_vld_q && fit) begin
          pos_d     = rd_idx_q;
          new_off_d = prev_end_q[31:0];
          ptr_d     = cnt_q;
          state_d   = S_SHIFT_UP;
        end else begin
          if (ptr_q < cnt_q) begin
            rd_en    = 1'b1;
            rd_addr  = ptr_q[IW-1:0];
            rd_idx_d = ptr_q[IW-1:0];
            rd_vld_d = 1'b1;
            ptr_d    = ptr_q + CW'(1);
          end
          if (rd_vld_q) begin
            prev_end_d = end_k;
            first_d    = 1'b0;
            if (rd_last) begin
              rd_en    = 1'b0;
              rd_vld_d = 1'b0;
              state_d  = S_PLACE;
            end
          end
        end
      end

      S_PLACE: begin
        if (place_over) begin
          rsp_d       = '{status: STAT_NOSPACE, range_offset: 32'd0, range_size: 32'd0};
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          pos_d     = cnt_q[IW-1:0];
          new_off_d = prev_end_q[31:0];
          ptr_d     = cnt_q;
          state_d   = S_SHIFT_UP;
        end
      end

      S_SHIFT_UP: begin
        // Read descending and write each entry one slot higher.
        if (ptr_q > CW'(pos_q)) begin
          rd_en    = 1'b1;
          rd_addr  = ptr_dec[IW-1:0];
          rd_idx_d = ptr_dec[IW-1:0];
          rd_vld_d = 1'b1;
          ptr_d    = ptr_dec;
        end
        if (rd_vld_q) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_q + IW'(1);
          wr_data = rd_data_q;
        end
        if ((ptr_q == CW'(pos_q)) && !rd_vld_q) begin
          state_d = S_INSERT;
        end
      end

      S_INSERT: begin
        wr_en          = 1'b1;
        wr_addr        = pos_q;
        wr_data        = '{offset: new_off_q, length: size_q};
        cnt_d          = cnt_q + CW'(1);
        cnt_op.take    = 1'b1;
        rsp_d          = '{status: STAT_OK, range_offset: new_off_q, range_size: size_q};
        rsp_valid_d    = 1'b1;
        state_d        = S_IDLE;
      end

      S_SCAN_F: begin
        if (rd_vld_q && (rd_data_q.offset == off_q)) begin
          len_d   = rd_data_q.length;
          pos_d   = rd_idx_q;
          ptr_d   = CW'(rd_idx_q) + CW'(1);
          state_d = S_SHIFT_DN;
        end else if (rd_vld_q && rd_last) begin
          rsp_d       = '{status: STAT_NOTFOUND, range_offset: off_q, range_size: 32'd0};
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (ptr_q < cnt_q) begin
          rd_en    = 1'b1;
          rd_addr  = ptr_q[IW-1:0];
          rd_idx_d = ptr_q[IW-1:0];
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + CW'(1);
        end
      end

      S_SHIFT_DN: begin
        // Read ascending and write each entry one slot lower.
        if (ptr_q < cnt_q) begin
          rd_en    = 1'b1;
          rd_addr  = ptr_q[IW-1:0];
          rd_idx_d = ptr_q[IW-1:0];
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + CW'(1);
        end
        if (rd_vld_q) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_q - IW'(1);
          wr_data = rd_data_q;
        end
        if ((ptr_q == cnt_q) && !rd_vld_q) begin
          state_d = S_REMOVE;
        end
      end

      S_REMOVE: begin
        cnt_d         = cnt_q - CW'(1);
        cnt_op.give   = 1'b1;
        cnt_op.amount = len_q;
        if ((CW'(pos_q) + CW'(1)) != cnt_q) begin
          gaps_d = 1'b1;
        end
        rsp_d       = '{status: (len_q != size_q) ? STAT_MISMATCH : STAT_OK,
                        range_offset: off_q, range_size: len_q};
        rsp_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      gaps_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gaps_q      <= gaps_d;
      rd_vld_q    <= rd_vld_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    off_q      <= off_d;
    ptr_q      <= ptr_d;
    pos_q      <= pos_d;
    first_q    <= first_d;
    prev_end_q <= prev_end_d;
    new_off_q  <= new_off_d;
    len_q      <= len_d;
    rd_idx_q   <= rd_idx_d;
    rsp_q      <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && (state_q == S_IDLE)))
    else $error("table written while idle");

  a_done_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> rsp_valid_o)
    else $error("item finished without a result");

  a_gaps_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gaps_q |=> gaps_q)
    else $error("gap flag cleared");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> rsp_valid_o)
    else $error("entry count changed without finishing an item");

endmodule

[verif/ffra_range_checker.sv]
// Scoreboard for the first-fit range allocator: predicts each result and compares it.
`timescale 1ns / 1ps
module ffra_range_checker #(
  parameter int unsigned MAX_ENTRIES = ffra_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  ffra_pkg::ffra_req_t            req_i,
  input  logic                           cfg_we_i,
  input  logic [31:0]                    cfg_wdata_i,
  input  logic                           rsp_valid_i,
  input  ffra_pkg::ffra_rsp_t            rsp_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             results_o,
  output logic [5:0][31:0]               status_hits_o,
  output int                             snap_count_o,
  output logic [MAX_ENTRIES-1:0][31:0]   snap_offset_o,
  output logic [MAX_ENTRIES-1:0][31:0]   snap_length_o
);
  import ffra_pkg::*;

  // Predicted copy of the allocator state.
  logic [31:0]                  region_q;
  logic [31:0]                  free_q;
  logic                         gaps_q;
  int                           tbl_count;
  logic [MAX_ENTRIES-1:0][31:0] tbl_offset;
  logic [MAX_ENTRIES-1:0][31:0] tbl_length;
  ffra_rsp_t                    range_expected [$];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count_o++;
    $display("[%0t] mismatch in %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
  endtask

  function automatic logic [33:0] entry_end(int idx);
    return {2'b00, tbl_offset[idx]} + {2'b00, tbl_length[idx]};
  endfunction

  // Keeps the bytes in use when the region is resized; the table stays as it is.
  function automatic void apply_region(logic [31:0] nv);
    logic [31:0] used;
    used = (free_q > region_q) ? 32'd0 : region_q - free_q;
    region_q = nv;
    free_q = (nv >= used) ? nv - used : 32'd0;
  endfunction

  function automatic ffra_rsp_t predict_range(ffra_req_t req);
    ffra_rsp_t   res;
    logic [33:0] cand;
    logic [33:0] nx;
    logic [33:0] gap;
    logic [32:0] sum;
    logic [31:0] len;
    int          i;
    int          pos;
    res.status = STAT_OK;
    res.range_offset = '0;
    res.range_size = '0;
    pos = -1;
    cand = '0;
    if (req.command == CMD_ALLOC) begin
      if (req.request_size == 32'd0) begin
        res.status = STAT_ZERO;
      end else if (tbl_count >= MAX_ENTRIES) begin
        res.status = STAT_FULL;
      end else if (gaps_q && free_q <= req.request_size) begin
        res.status = STAT_NOSPACE;
      end else begin
        if (gaps_q) begin
          for (i = 0; i + 1 < tbl_count; i++) begin
            nx = {2'b00, tbl_offset[i+1]};
            gap = (nx > entry_end(i)) ? nx - entry_end(i) : 34'd0;
            if (pos < 0 && gap >= {2'b00, req.request_size}) begin
              pos = i + 1;
              cand = entry_end(i);
            end
          end
        end
        if (pos < 0) begin
          cand = (tbl_count == 0) ? 34'd0 : entry_end(tbl_count - 1);
          if (cand + {2'b00, req.request_size} <= {2'b00, region_q}) pos = tbl_count;
        end
        if (pos < 0) begin
          res.status = STAT_NOSPACE;
        end else begin
          for (i = tbl_count; i > pos; i--) begin
            tbl_offset[i] = tbl_offset[i-1];
            tbl_length[i] = tbl_length[i-1];
          end
          tbl_offset[pos] = cand[31:0];
          tbl_length[pos] = req.request_size;
          tbl_count++;
          free_q = (free_q >= req.request_size) ? free_q - req.request_size : 32'd0;
          res.range_offset = cand[31:0];
          res.range_size = req.request_size;
        end
      end
    end else begin
      for (i = 0; i < tbl_count; i++) begin
        if (pos < 0 && tbl_offset[i] == req.free_offset) pos = i;
      end
      res.range_offset = req.free_offset;
      if (pos < 0) begin
        res.status = STAT_NOTFOUND;
      end else begin
        len = tbl_length[pos];
        sum = {1'b0, free_q} + {1'b0, len};
        free_q = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (pos + 1 != tbl_count) gaps_q = 1'b1;
        for (i = pos; i + 1 < tbl_count; i++) begin
          tbl_offset[i] = tbl_offset[i+1];
          tbl_length[i] = tbl_length[i+1];
        end
        tbl_count--;
        res.status = (len != req.request_size) ? STAT_MISMATCH : STAT_OK;
        res.range_size = len;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    ffra_rsp_t want;
    if (!rst_ni) begin
      region_q = '0;
      free_q = '0;
      gaps_q = 1'b0;
      tbl_count = 0;
      tbl_offset = '0;
      tbl_length = '0;
      range_expected.delete();
      fail_count_o = 0;
      results_o = 0;
      status_hits_o = '0;
    end else begin
      // Compare before predicting: a result never belongs to the item taken at this edge.
      if (rsp_valid_i) begin
        results_o++;
        if (rsp_i.status <= STAT_NOTFOUND) begin
          status_hits_o[rsp_i.status] = status_hits_o[rsp_i.status] + 1;
        end
        if (range_expected.size() == 0) begin
          report_mismatch("result with nothing expected", rsp_i.range_offset, '0);
        end else begin
          want = range_expected.pop_front();
          if (rsp_i.status !== want.status) begin
            report_mismatch("status", 32'(rsp_i.status), 32'(want.status));
          end
          if (rsp_i.range_offset !== want.range_offset) begin
            report_mismatch("range_offset", rsp_i.range_offset, want.range_offset);
          end
          if (rsp_i.range_size !== want.range_size) begin
            report_mismatch("range_size", rsp_i.range_size, want.range_size);
          end
        end
      end
      if (cfg_we_i) apply_region(cfg_wdata_i);
      if (start_i && !busy_i) begin
        range_expected.insert(range_expected.size(), predict_range(req_i));
      end
    end
    pending_o <= range_expected.size();
    snap_count_o <= tbl_count;
    snap_offset_o <= tbl_offset;
    snap_length_o <= tbl_length;
  end

endmodule

[verif/first_fit_range_allocator_tb.sv]
// Top-level testbench for the first-fit range allocator: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module first_fit_range_allocator_tb;
  import ffra_pkg::*;

  localparam int unsigned MAX_ENTRIES = DEFAULT_MAX_ENTRIES;
  localparam int          ITEMS       = 1950;
  localparam int          CALM_ITEMS  = 200;
  // Far longer than the slowest item takes to finish.
  localparam int          QUIET_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  ffra_req_t   req = '0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        busy;
  logic        rsp_valid;
  ffra_rsp_t   rsp;

  int                           fail_count;
  int                           pending;
  int                           results;
  int                           snap_count;
  logic [5:0][31:0]             status_hits;
  logic [MAX_ENTRIES-1:0][31:0] snap_offset;
  logic [MAX_ENTRIES-1:0][31:0] snap_length;

  logic [31:0] region_now = '0;
  int          n_alloc = 0;
  int          n_free = 0;
  int          n_cfg = 0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  first_fit_range_allocator #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp)
  );

  ffra_range_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .rsp_valid_i  (rsp_valid),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .status_hits_o(status_hits),
    .snap_count_o (snap_count),
    .snap_offset_o(snap_offset),
    .snap_length_o(snap_length)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || rsp_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no activity for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Leaves start high on return so that a following item can go out back to back.
  task automatic send_item(ffra_cmd_e cmd, logic [31:0] size, logic [31:0] offset);
    start <= 1'b1;
    req <= '{command: cmd, request_size: size, free_offset: offset};
    do @(posedge clk); while (busy);
    if (cmd == CMD_ALLOC) n_alloc++;
    else n_free++;
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_region(logic [31:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    region_now = value;
    n_cfg++;
  endtask

  task automatic random_item(int alloc_pct, bit fill);
    logic [31:0] size;
    logic [31:0] offset;
    logic [31:0] cap;
    int          roll;
    int          idx;
    roll = $urandom_range(99, 0);
    cap = (region_now / 48 == 0) ? 32'd1 : region_now / 48;
    if (fill) begin
      send_item(CMD_ALLOC, $urandom_range(256, 1), $urandom());
    end else if ($urandom_range(99, 0) < alloc_pct) begin
      if (roll < 3) size = 32'd0;
      else if (roll < 6) size = 32'hFFFF_FFFF;
      else if (roll < 14) size = $urandom();
      else if (roll < 22) size = region_now >> $urandom_range(8, 0);
      else size = $urandom_range(cap, 1);
      send_item(CMD_ALLOC, size, $urandom());
    end else begin
      // Most frees target a live range; the rest are misses near or far from one.
      if (snap_count > 0 && roll < 80) begin
        idx = $urandom_range(snap_count - 1, 0);
        offset = snap_offset[idx];
        size = ($urandom_range(3, 0) != 0) ? snap_length[idx] : $urandom();
      end else if (snap_count > 0 && roll < 90) begin
        idx = $urandom_range(snap_count - 1, 0);
        offset = snap_offset[idx] + 32'd1;
        size = snap_length[idx];
      end else begin
        offset = $urandom();
        size = $urandom();
      end
      send_item(CMD_FREE, size, offset);
    end
  endtask

  initial begin : stimulus
    logic [31:0] value;
    int          kind;
    int          phase_len;
    int          pause_at;
    int          alloc_pct;
    int          j;
    bit          fill;
    bit          idle_on;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Region is zero after reset: only rejections are possible.
    send_item(CMD_ALLOC, 32'd0, 32'd0);
    send_item(CMD_ALLOC, 32'd1, 32'd0);
    send_item(CMD_FREE, 32'd5, 32'd0);

    write_region(32'd1000);
    send_item(CMD_ALLOC, 32'd100, 32'd0);
    send_item(CMD_ALLOC, 32'd200, 32'd0);
    send_item(CMD_ALLOC, 32'd300, 32'd0);
    // Freeing an inner range opens a gap that later allocations must fill first.
    send_item(CMD_FREE, 32'd200, 32'd100);
    send_item(CMD_ALLOC, 32'd50, 32'd0);
    send_item(CMD_ALLOC, 32'd150, 32'd0);
    send_item(CMD_ALLOC, 32'd1000, 32'd0);
    send_item(CMD_FREE, 32'd7, 32'd300);
    send_item(CMD_FREE, 32'd1, 32'h0001_2345);
    send_item(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    write_region(32'hFFFF_FFFF);
    send_item(CMD_ALLOC, 32'h8000_0000, 32'd0);
    send_item(CMD_ALLOC, 32'h7FFF_FFFF, 32'd0);
    // Shrink below the bytes in use, then grow again, so that the free
    // count runs into its upper limit when the big range comes back.
    write_region(32'h0000_0100);
    write_region(32'hFFFF_FFFF);
    send_item(CMD_FREE, 32'h8000_0000, 32'd300);
    send_item(CMD_FREE, 32'd100, 32'd0);
    send_item(CMD_FREE, 32'd50, 32'd100);
    send_item(CMD_FREE, 32'd150, 32'd150);
    send_item(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_item(CMD_ALLOC, 32'd1, 32'd0);
    send_item(CMD_FREE, 32'd1, 32'd0);

    while (n_alloc + n_free < ITEMS) begin
      idle_on = (n_alloc + n_free) < ITEMS - CALM_ITEMS;
      fill = ($urandom_range(4, 0) == 0);
      kind = $urandom_range(99, 0);
      if (fill || kind < 20) value = 32'hFFFF_FFFF;
      else if (kind < 25) value = 32'd0;
      else if (kind < 40) value = $urandom_range(64, 1);
      else if (kind < 70) value = $urandom_range(65535, 256);
      else value = $urandom();
      write_region(value);
      case ($urandom_range(2, 0))
        0: alloc_pct = 85;
        1: alloc_pct = 60;
        default: alloc_pct = 35;
      endcase
      phase_len = fill ? MAX_ENTRIES + 8 : $urandom_range(120, 40);
      pause_at = $urandom_range(phase_len - 1, 0);
      for (j = 0; j < phase_len; j++) begin
        idle_on = (n_alloc + n_free) < ITEMS - CALM_ITEMS;
        if (idle_on && j == pause_at) begin
          settle();
        end else if (idle_on && $urandom_range(3, 0) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        random_item(alloc_pct, fill);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d allocate and %0d free items under %0d region settings",
             n_alloc, n_free, n_cfg);
    $display("checked %0d results: ok %0d, zero %0d, no space %0d, full %0d,",
             results, status_hits[STAT_OK], status_hits[STAT_ZERO],
             status_hits[STAT_NOSPACE], status_hits[STAT_FULL]);
    $display("  mismatch %0d, missing %0d",
             status_hits[STAT_MISMATCH], status_hits[STAT_NOTFOUND]);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
